>>> hw/rtl/pgr_pkg.sv
// Shared constants and register codes for the perspective glyph rectangle block.
`default_nettype none
package pgr_pkg;

	localparam int POW_ENTRIES_DEF = 256;
	localparam int DIV_LAT = 40;

	localparam logic [21:0] LOG2_10_Q20 = 22'd3483294;
	localparam longint unsigned LN2_Q32 = 64'd2977044472;
	localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
	localparam logic [16:0] ONE_Q16 = 17'h10000;

	typedef enum logic [2:0] {
		REG_PLAYER_DISTANCE  = 3'd0,
		REG_HIGHWAY_DEPTH    = 3'd1,
		REG_PERSP_STRENGTH   = 3'd2,
		REG_BAR_RATIO        = 3'd3,
		REG_REGULAR_RATIO    = 3'd4,
		REG_CURVE_EXPONENT   = 3'd5,
		REG_OFFSET_MULT      = 3'd6
	} reg_idx_t;

endpackage
`default_nettype wire

>>> hw/rtl/perspective_glyph_rect.sv
// Top level: fixed-point perspective rectangle of one glyph, fully pipelined.
//
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------------------
//  input   | start / busy           | depth, near/far y, x, width, width_scale,
//          |                        | is_bar, view_width, view_height
//  config  | cfg_we                 | cfg_index, cfg_data
//  result  | done (one-cycle strobe)| rect_x, rect_y, rect_width, rect_height
//
// One word in per cycle; busy is never raised. Eight stages do scaling, exp2 lookup
// and interpolation, then 40 stages of the three dividers (one quotient bit per stage
// up to each quotient's width; the 40-bit height quotient is the widest), five to
// blend and saturate. Reset clears valid bits and the configuration registers;
// no clearing pass. The receiver cannot stall, so the pipe never holds.
`default_nettype none
module perspective_glyph_rect import pgr_pkg::*; #(
	parameter int POW_TABLE_ENTRIES = POW_ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic [16:0]        depth,
	input  logic signed [17:0] near_y,
	input  logic signed [17:0] far_y,
	input  logic signed [17:0] near_x,
	input  logic signed [17:0] far_x,
	input  logic [16:0]        near_width,
	input  logic [16:0]        far_width,
	input  logic [16:0]        width_scale,
	input  logic               is_bar,
	input  logic [13:0]        view_width,
	input  logic [13:0]        view_height,
	output logic               done,
	output logic signed [23:0] rect_x,
	output logic signed [23:0] rect_y,
	output logic [22:0]        rect_width,
	output logic [22:0]        rect_height
);

	localparam int IW = $clog2(POW_TABLE_ENTRIES + 1);
	localparam int PW = IW + 18;

	typedef struct packed {
		logic [16:0]        omd;
		logic [17:0]        swn;
		logic [17:0]        swf;
		logic [13:0]        w;
		logic [15:0]        ratio;
		logic signed [33:0] ydh;
		logic signed [32:0] yfh;
		logic signed [36:0] xdw;
		logic signed [35:0] axfw;
		logic [31:0]        tw;
		logic signed [36:0] offs;
		logic [32:0]        hdo;
	} side_t;

	typedef struct packed {
		logic  den0;
		side_t s;
	} div_side_t;

	localparam int SW = $bits(div_side_t);

	function automatic longint unsigned div_small(input longint unsigned x, input int n);
		case (n)
			2:  return x / 64'd2;
			3:  return x / 64'd3;
			4:  return x / 64'd4;
			5:  return x / 64'd5;
			6:  return x / 64'd6;
			7:  return x / 64'd7;
			8:  return x / 64'd8;
			9:  return x / 64'd9;
			10: return x / 64'd10;
			11: return x / 64'd11;
			12: return x / 64'd12;
			13: return x / 64'd13;
			14: return x / 64'd14;
			15: return x / 64'd15;
			16: return x / 64'd16;
			17: return x / 64'd17;
			18: return x / 64'd18;
			19: return x / 64'd19;
			20: return x / 64'd20;
			default: return x;
		endcase
	endfunction

	// 2^(j/N) in Q.32 by a truncated Taylor series of e^(j ln2 / N)
	function automatic logic [33:0] exp_entry(input int j);
		longint unsigned z;
		longint unsigned sum;
		longint unsigned term;
		z = (64'(j) * LN2_Q32) / POW_TABLE_ENTRIES;
		sum = 64'h1_0000_0000;
		term = 64'h1_0000_0000;
		for (int k = 1; k <= 20; k++) begin
			term = div_small((term * z) >> 32, k);
			sum = sum + term;
		end
		return 34'(sum);
	endfunction

	function automatic logic signed [23:0] sat_s24(input logic signed [33:0] v);
		if (v > 34'sd8388607) return 24'sh7FFFFF;
		if (v < -34'sd8388608) return 24'sh800000;
		return 24'(v);
	endfunction

	logic [33:0] tab [POW_TABLE_ENTRIES+1];
	for (genvar j = 0; j <= POW_TABLE_ENTRIES; j++) begin : g_tab
		assign tab[j] = exp_entry(j);
	end

	// configuration
	logic [15:0] pd_q, hd_q, str_q, barr_q, regr_q, k_q, off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pd_q   <= 16'd256;
			hd_q   <= 16'd256;
			str_q  <= 16'd4096;
			barr_q <= 16'd256;
			regr_q <= 16'd256;
			k_q    <= 16'd4096;
			off_q  <= 16'd0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_PLAYER_DISTANCE: pd_q   <= cfg_data;
				REG_HIGHWAY_DEPTH:   hd_q   <= cfg_data;
				REG_PERSP_STRENGTH:  str_q  <= cfg_data;
				REG_BAR_RATIO:       barr_q <= cfg_data;
				REG_REGULAR_RATIO:   regr_q <= cfg_data;
				REG_CURVE_EXPONENT:  k_q    <= cfg_data;
				REG_OFFSET_MULT:     off_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	logic        accept;
	logic [15:0] pd_c, k_c, ratio_c, ratio_raw;
	logic [16:0] d_c, omd_c;

	assign busy      = 1'b0;
	assign accept    = start && !busy;
	assign pd_c      = (pd_q == 16'd0) ? 16'd1 : pd_q;
	assign k_c       = (k_q == 16'd0) ? 16'd1 : k_q;
	assign ratio_raw = is_bar ? barr_q : regr_q;
	assign ratio_c   = (ratio_raw == 16'd0) ? 16'd1 : ratio_raw;
	assign d_c       = (depth > ONE_Q16) ? ONE_Q16 : depth;
	assign omd_c     = ONE_Q16 - d_c;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic v_dv, v_s9, v_s10, v_s11, v_s12, v_s13;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0; v_s2  <= 1'b0; v_s3  <= 1'b0; v_s4  <= 1'b0;
			v_s5  <= 1'b0; v_s6  <= 1'b0; v_s7  <= 1'b0; v_s8  <= 1'b0;
			v_s9  <= 1'b0; v_s10 <= 1'b0; v_s11 <= 1'b0; v_s12 <= 1'b0;
			v_s13 <= 1'b0;
		end else begin
			v_s1  <= accept;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_dv;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
		end
	end

	// stage 1: width scaling and curve products
	logic [16:0]        omd_s1, wn_s1, wf_s1;
	logic [33:0]        swnp_s1, swfp_s1;
	logic [37:0]        kl_s1;
	logic [32:0]        kom_s1;
	logic signed [17:0] yn_s1, yf_s1, xn_s1, xf_s1;
	logic [13:0]        w_s1, h_s1;
	logic [15:0]        ratio_s1;

	always_ff @(posedge clk) begin
		omd_s1   <= omd_c;
		wn_s1    <= near_width;
		wf_s1    <= far_width;
		swnp_s1  <= 34'(near_width) * 34'(width_scale);
		swfp_s1  <= 34'(far_width) * 34'(width_scale);
		kl_s1    <= 38'(k_c) * 38'(LOG2_10_Q20);
		kom_s1   <= 33'(k_c) * 33'(omd_c);
		yn_s1    <= near_y;
		yf_s1    <= far_y;
		xn_s1    <= near_x;
		xf_s1    <= far_x;
		w_s1     <= view_width;
		h_s1     <= view_height;
		ratio_s1 <= ratio_c;
	end

	// stage 2: re-centre, exponent product, pixel products
	logic [17:0]        swn_c, swf_c;
	logic signed [19:0] dxn_c, dxf_c;
	logic signed [18:0] dy_c;
	logic signed [14:0] hs_c;

	assign swn_c = swnp_s1[33:16];
	assign swf_c = swfp_s1[33:16];
	assign dxn_c = $signed({3'b0, wn_s1}) - $signed({2'b0, swn_c});
	assign dxf_c = $signed({3'b0, wf_s1}) - $signed({2'b0, swf_c});
	assign dy_c  = 19'(yn_s1) - 19'(yf_s1);
	assign hs_c  = $signed({1'b0, h_s1});

	logic [54:0]        aprod_s2;
	logic [21:0]        b_s2;
	logic [17:0]        swn_s2, swf_s2;
	logic signed [20:0] axn_s2, axf_s2;
	logic [31:0]        tw_s2;
	logic [32:0]        hdo_s2;
	logic signed [33:0] ydh_s2;
	logic signed [32:0] yfh_s2;
	logic [16:0]        omd_s2;
	logic [13:0]        w_s2;
	logic [15:0]        ratio_s2;

	always_ff @(posedge clk) begin
		aprod_s2 <= 55'(kom_s1) * 55'(LOG2_10_Q20);
		b_s2     <= kl_s1[37:16];
		swn_s2   <= swn_c;
		swf_s2   <= swf_c;
		axn_s2   <= 21'(xn_s1) + 21'(dxn_c >>> 1);
		axf_s2   <= 21'(xf_s1) + 21'(dxf_c >>> 1);
		tw_s2    <= 32'(swf_c) * 32'(w_s1);
		hdo_s2   <= 33'(hd_q) * 33'(omd_s1);
		ydh_s2   <= 34'(dy_c) * 34'(hs_c);
		yfh_s2   <= 33'(yf_s1) * 33'(hs_c);
		omd_s2   <= omd_s1;
		w_s2     <= w_s1;
		ratio_s2 <= ratio_s1;
	end

	// stage 3: exponents a, b, b-a and x products
	logic [21:0]        a_c;
	logic signed [14:0] ws_c;
	logic signed [21:0] dax_c;
	logic signed [48:0] offp_c;

	assign a_c    = aprod_s2[53:32];
	assign ws_c   = $signed({1'b0, w_s2});
	assign dax_c  = 22'(axn_s2) - 22'(axf_s2);
	assign offp_c = 49'($signed({1'b0, tw_s2})) * 49'($signed(off_q));

	logic [21:0] y_s3 [3];
	side_t       side_s3;

	always_ff @(posedge clk) begin
		y_s3[0]       <= a_c;
		y_s3[1]       <= b_s2;
		y_s3[2]       <= b_s2 - a_c;
		side_s3.omd   <= omd_s2;
		side_s3.swn   <= swn_s2;
		side_s3.swf   <= swf_s2;
		side_s3.w     <= w_s2;
		side_s3.ratio <= ratio_s2;
		side_s3.ydh   <= ydh_s2;
		side_s3.yfh   <= yfh_s2;
		side_s3.xdw   <= 37'(dax_c) * 37'(ws_c);
		side_s3.axfw  <= 36'(axf_s2) * 36'(ws_c);
		side_s3.tw    <= tw_s2;
		side_s3.offs  <= 37'(offp_c >>> 12);
		side_s3.hdo   <= hdo_s2;
	end

	// stages 4..7: 2^-y for three lanes
	logic [PW-1:0]   pos_c  [3];
	logic [IW+1:0]   idxf_c [3];
	logic [IW-1:0]   idx_c  [3];

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			pos_c[l]  = PW'(ONE_Q16 - {1'b0, y_s3[l][15:0]}) * PW'(POW_TABLE_ENTRIES);
			idxf_c[l] = pos_c[l][PW-1:16];
			idx_c[l]  = (idxf_c[l] > (IW+2)'(POW_TABLE_ENTRIES - 1)) ?
				IW'(POW_TABLE_ENTRIES - 1) : idxf_c[l][IW-1:0];
		end
	end

	logic [5:0]    ip_s4 [3], ip_s5 [3], ip_s6 [3];
	logic [2:0]    fz_s4, fz_s5, fz_s6;
	logic [IW-1:0] idx_s4 [3];
	logic [15:0]   rem_s4 [3], rem_s5 [3];
	logic [33:0]   t0_s5 [3], dt_s5 [3], t0_s6 [3];
	logic [49:0]   pr_s6 [3];
	logic [32:0]   e_s7 [3];
	side_t         side_s4, side_s5, side_s6, side_s7;

	logic [34:0] iv_c [3];
	logic [6:0]  sh_c [3];
	logic [32:0] e_c  [3];

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			iv_c[l] = {1'b0, t0_s6[l]} + {1'b0, pr_s6[l][49:16]};
			sh_c[l] = {1'b0, ip_s6[l]} + 7'd1;
			if (fz_s6[l]) begin
				e_c[l] = ONE_Q32 >> ip_s6[l];
			end else if (ip_s6[l] == 6'd63) begin
				e_c[l] = '0;
			end else begin
				e_c[l] = 33'(iv_c[l] >> sh_c[l]);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 3; l++) begin
			ip_s4[l]  <= y_s3[l][21:16];
			fz_s4[l]  <= (y_s3[l][15:0] == 16'd0);
			idx_s4[l] <= idx_c[l];
			rem_s4[l] <= pos_c[l][15:0];

			ip_s5[l]  <= ip_s4[l];
			fz_s5[l]  <= fz_s4[l];
			rem_s5[l] <= rem_s4[l];
			t0_s5[l]  <= tab[idx_s4[l]];
			dt_s5[l]  <= tab[IW'(idx_s4[l] + 1'b1)] - tab[idx_s4[l]];

			ip_s6[l]  <= ip_s5[l];
			fz_s6[l]  <= fz_s5[l];
			t0_s6[l]  <= t0_s5[l];
			pr_s6[l]  <= 50'(dt_s5[l]) * 50'(rem_s5[l]);

			e_s7[l]   <= e_c[l];
		end
		side_s4 <= side_s3;
		side_s5 <= side_s4;
		side_s6 <= side_s5;
		side_s7 <= side_s6;
	end

	// stage 8: progress numerator and denominator
	logic [32:0] num_c, den_c;
	logic [49:0] np_s8;
	logic [32:0] den_s8;
	div_side_t   dside_s8;

	assign num_c = ONE_Q32 - e_s7[0];
	assign den_c = ONE_Q32 - e_s7[1];

	always_ff @(posedge clk) begin
		np_s8         <= 50'(e_s7[2][32:16]) * 50'(num_c);
		den_s8        <= den_c;
		dside_s8.den0 <= (den_c == 33'd0);
		dside_s8.s    <= side_s7;
	end

	// dividers, all of the same length so their words line up
	logic [16:0]   qp;
	logic          ovfp;
	logic [SW-1:0] pside;
	div_side_t     ds_o;
	logic [39:0]   qth;
	logic [32:0]   qe;

	pgr_div #(.NW(50), .DW(33), .QW(17), .LAT(DIV_LAT), .SW(SW)) u_pdiv (
		.clk(clk), .arst_n(arst_n), .vin(v_s8),
		.n(np_s8), .d(den_s8), .side_in(SW'(dside_s8)),
		.q(qp), .ovf(ovfp), .vout(v_dv), .side_out(pside)
	);

	pgr_div #(.NW(40), .DW(16), .QW(40), .LAT(DIV_LAT), .SW(1)) u_thdiv (
		.clk(clk), .arst_n(arst_n), .vin(v_s8),
		.n({dside_s8.s.tw, 8'd0}), .d(dside_s8.s.ratio), .side_in(1'b0),
		.q(qth), .ovf(), .vout(), .side_out()
	);

	pgr_div #(.NW(33), .DW(16), .QW(33), .LAT(DIV_LAT), .SW(1)) u_ediv (
		.clk(clk), .arst_n(arst_n), .vin(v_s8),
		.n(dside_s8.s.hdo), .d(pd_c), .side_in(1'b0),
		.q(qe), .ovf(), .vout(), .side_out()
	);

	assign ds_o = div_side_t'(pside);

	// stage 9: progress with cap and degenerate case
	logic [16:0] p_s9;
	logic [39:0] th_s9;
	logic [31:0] e_s9;
	side_t       side_s9;

	always_ff @(posedge clk) begin
		if (ds_o.den0) begin
			p_s9 <= ds_o.s.omd;
		end else if (ovfp || qp > ONE_Q16) begin
			p_s9 <= ONE_Q16;
		end else begin
			p_s9 <= qp;
		end
		th_s9   <= qth;
		e_s9    <= qe[31:0];
		side_s9 <= ds_o.s;
	end

	// stage 10: blend products
	logic signed [17:0] psg_c;
	logic signed [18:0] dsw_c;

	assign psg_c = $signed({1'b0, p_s9});
	assign dsw_c = $signed({1'b0, side_s9.swn}) - $signed({1'b0, side_s9.swf});

	logic signed [36:0] iwd_s10;
	logic signed [51:0] yd_s10;
	logic signed [54:0] xd_s10;
	logic [47:0]        es_s10;
	logic [39:0]        th_s10;
	side_t              side_s10;

	always_ff @(posedge clk) begin
		iwd_s10  <= 37'(dsw_c) * 37'(psg_c);
		yd_s10   <= 52'(side_s9.ydh) * 52'(psg_c);
		xd_s10   <= 55'(side_s9.xdw) * 55'(psg_c);
		es_s10   <= 48'(e_s9) * 48'(str_q);
		th_s10   <= th_s9;
		side_s10 <= side_s9;
	end

	// stage 11: blended values and perspective scale
	logic signed [21:0] iw_s11;
	logic signed [36:0] ypos_s11;
	logic signed [39:0] xpos_s11;
	logic [36:0]        ps_s11;
	logic [39:0]        th_s11;
	logic [31:0]        tw_s11;
	logic signed [36:0] offs_s11;
	logic [13:0]        w_s11;

	always_ff @(posedge clk) begin
		iw_s11   <= 22'($signed({1'b0, side_s10.swf})) + 22'(iwd_s10 >>> 16);
		ypos_s11 <= 37'(side_s10.yfh) + 37'(yd_s10 >>> 16);
		xpos_s11 <= 40'(side_s10.axfw) + 40'(xd_s10 >>> 16);
		ps_s11   <= 37'(ONE_Q16) + 37'(es_s10[47:12]);
		th_s11   <= th_s10;
		tw_s11   <= side_s10.tw;
		offs_s11 <= side_s10.offs;
		w_s11    <= side_s10.w;
	end

	// stage 12: edges, width in pixels, height partial products
	logic signed [41:0] fx_s12, fy_s12;
	logic signed [36:0] iww_s12;
	logic               thbig_s12;
	logic [49:0]        pph_s12;
	logic [48:0]        ppl_s12;

	always_ff @(posedge clk) begin
		fx_s12    <= 42'(xpos_s11) + 42'(offs_s11) - 42'($signed({1'b0, tw_s11[31:1]}));
		fy_s12    <= 42'(ypos_s11) - 42'($signed({1'b0, th_s11[39:1]}));
		iww_s12   <= 37'(iw_s11) * 37'($signed({1'b0, w_s11}));
		// a height of 2^31 or more saturates whatever the scale
		thbig_s12 <= |th_s11[39:31];
		pph_s12   <= 50'(th_s11[30:0]) * 50'(ps_s11[36:18]);
		ppl_s12   <= 49'(th_s11[30:0]) * 49'(ps_s11[17:0]);
	end

	// stage 13: saturate into the result word
	logic [68:0]        hsum_c;
	logic signed [28:0] iwp_c;

	assign hsum_c = (69'(pph_s12) << 18) + 69'(ppl_s12);
	assign iwp_c  = 29'(iww_s12 >>> 8);

	logic signed [23:0] rx_s13, ry_s13;
	logic [22:0]        rw_s13, rh_s13;

	always_ff @(posedge clk) begin
		rx_s13 <= sat_s24(34'(fx_s12 >>> 8));
		ry_s13 <= sat_s24(34'(fy_s12 >>> 8));
		if (iwp_c < 29'sd0) begin
			rw_s13 <= '0;
		end else if (iwp_c > 29'sd8388607) begin
			rw_s13 <= 23'h7FFFFF;
		end else begin
			rw_s13 <= 23'(iwp_c);
		end
		if (thbig_s12 || (|hsum_c[68:47])) begin
			rh_s13 <= 23'h7FFFFF;
		end else begin
			rh_s13 <= hsum_c[46:24];
		end
	end

	assign done        = v_s13;
	assign rect_x      = rx_s13;
	assign rect_y      = ry_s13;
	assign rect_width  = rw_s13;
	assign rect_height = rh_s13;

endmodule
`default_nettype wire

>>> hw/rtl/pgr_div.sv
// Restoring divider pipe, one quotient bit per stage up to QW, side data carried along.
`default_nettype none
module pgr_div import pgr_pkg::*; #(
	parameter int NW  = 32,
	parameter int DW  = 16,
	parameter int QW  = 32,
	parameter int LAT = DIV_LAT,
	parameter int SW  = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vin,
	input  logic [NW-1:0] n,
	input  logic [DW-1:0] d,
	input  logic [SW-1:0] side_in,
	output logic [QW-1:0] q,
	output logic          ovf,
	output logic          vout,
	output logic [SW-1:0] side_out
);

	localparam int XW = ((NW > DW + QW) ? NW : DW + QW) + 1;

	logic [LAT-1:0] v_s;
	logic [LAT-1:0] ovf_s;
	logic [NW-1:0]  r_s  [LAT];
	logic [QW-1:0]  q_s  [LAT];
	logic [DW-1:0]  d_s  [LAT];
	logic [SW-1:0]  sd_s [LAT];

	for (genvar i = 0; i < LAT; i++) begin : g_st
		logic          vi;
		logic          o_in;
		logic [NW-1:0] r_in;
		logic [QW-1:0] q_in;
		logic [DW-1:0] d_in;
		logic [SW-1:0] s_in;
		logic [NW-1:0] r_nx;
		logic [QW-1:0] q_nx;

		if (i == 0) begin : g_first
			assign vi   = vin;
			assign r_in = n;
			assign q_in = '0;
			assign d_in = d;
			assign s_in = side_in;
			assign o_in = XW'(n) >= (XW'(d) << QW);
		end else begin : g_next
			assign vi   = v_s[i-1];
			assign r_in = r_s[i-1];
			assign q_in = q_s[i-1];
			assign d_in = d_s[i-1];
			assign s_in = sd_s[i-1];
			assign o_in = ovf_s[i-1];
		end

		if (i < QW) begin : g_step
			localparam int J = QW - 1 - i;
			logic [XW-1:0] dsh;
			logic          ge;
			assign dsh  = XW'(d_in) << J;
			assign ge   = XW'(r_in) >= dsh;
			assign r_nx = ge ? NW'(XW'(r_in) - dsh) : r_in;
			assign q_nx = q_in | (QW'(ge) << J);
		end else begin : g_hold
			assign r_nx = r_in;
			assign q_nx = q_in;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else begin
				v_s[i] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			r_s[i]   <= r_nx;
			q_s[i]   <= q_nx;
			d_s[i]   <= d_in;
			sd_s[i]  <= s_in;
			ovf_s[i] <= o_in;
		end
	end

	assign q        = q_s[LAT-1];
	assign ovf      = ovf_s[LAT-1];
	assign vout     = v_s[LAT-1];
	assign side_out = sd_s[LAT-1];

endmodule
`default_nettype wire

>>> tb/sv/pgr_checker.sv
// Checker: watches the glyph block's ports, predicts each rectangle and compares.
module pgr_checker import pgr_pkg::*; #(
	parameter int POW_TABLE_ENTRIES = POW_ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic [16:0]        depth,
	input  logic signed [17:0] near_y,
	input  logic signed [17:0] far_y,
	input  logic signed [17:0] near_x,
	input  logic signed [17:0] far_x,
	input  logic [16:0]        near_width,
	input  logic [16:0]        far_width,
	input  logic [16:0]        width_scale,
	input  logic               is_bar,
	input  logic [13:0]        view_width,
	input  logic [13:0]        view_height,
	input  logic               done,
	input  logic signed [23:0] rect_x,
	input  logic signed [23:0] rect_y,
	input  logic [22:0]        rect_width,
	input  logic [22:0]        rect_height,
	output int                 errors,
	output int                 pending
);
	typedef struct {
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic [22:0]        w;
		logic [22:0]        h;
	} rect_t;

	localparam longint unsigned ONE32 = 64'h1_0000_0000;
	localparam longint unsigned L2T = longint'(LOG2_10_Q20);

	rect_t rect_q[$];
	longint unsigned pow_tab[POW_TABLE_ENTRIES + 1];
	logic [15:0] dist_r, hwy_r, strength_r, bar_ratio_r, reg_ratio_r, curve_r, offset_r;

	initial begin
		longint unsigned z, sum, term;
		for (int j = 0; j <= POW_TABLE_ENTRIES; j++) begin
			z = (longint'(j) * LN2_Q32) / POW_TABLE_ENTRIES;
			sum = ONE32;
			term = ONE32;
			for (int n = 1; n <= 20; n++) begin
				term = ((term * z) >> 32) / longint'(n);
				sum += term;
			end
			pow_tab[j] = sum;
		end
	end

	function automatic longint unsigned frac_exp2(longint unsigned f);
		longint unsigned pos, idx, rem;
		pos = f * POW_TABLE_ENTRIES;
		idx = pos >> 16;
		rem = pos & 64'hFFFF;
		if (idx >= POW_TABLE_ENTRIES) idx = POW_TABLE_ENTRIES - 1;
		return pow_tab[idx] + (((pow_tab[idx + 1] - pow_tab[idx]) * rem) >> 16);
	endfunction

	// 2^-y, y in Q.16, result Q.32
	function automatic longint unsigned exp2_neg(longint unsigned y);
		longint unsigned ip, fp;
		ip = y >> 16;
		fp = y & 64'hFFFF;
		if (fp == 0) return ip >= 64 ? 0 : (ONE32 >> ip);
		if (ip + 1 >= 64) return 0;
		return frac_exp2(65536 - fp) >> (ip + 1);
	endfunction

	function automatic logic [23:0] clamp_s24(longint v);
		if (v > 8388607) v = 8388607;
		if (v < -8388608) v = -8388608;
		return v[23:0];
	endfunction

	function automatic logic [22:0] clamp_u23(longint v);
		if (v < 0) v = 0;
		if (v > 8388607) v = 8388607;
		return v[22:0];
	endfunction

	function automatic rect_t glyph_rect(
		logic [16:0] d_in, logic signed [17:0] yn_i, logic signed [17:0] yf_i,
		logic signed [17:0] xn_i, logic signed [17:0] xf_i, logic [16:0] wn_i,
		logic [16:0] wf_i, logic [16:0] sc_i, logic bar, logic [13:0] w_i, logic [13:0] h_i);
		longint unsigned d, omd, a, b, num, den, p, e16, ps, th, pd, k, ratio, hu;
		longint yn, yf, xn, xf, wn, wf, sc, vw, vh;
		longint swn, swf, axn, axf, tw, pi, iw, ypos, xpos, fx, fy, ht;
		rect_t r;
		yn = yn_i; yf = yf_i; xn = xn_i; xf = xf_i;
		wn = longint'(wn_i); wf = longint'(wf_i); sc = longint'(sc_i);
		vw = longint'(w_i); vh = longint'(h_i);
		pd = dist_r == 0 ? 1 : dist_r;
		k = curve_r == 0 ? 1 : curve_r;
		ratio = bar ? bar_ratio_r : reg_ratio_r;
		if (ratio == 0) ratio = 1;
		d = d_in;
		if (d > 65536) d = 65536;
		omd = 65536 - d;

		swn = (wn * sc) >>> 16;
		swf = (wf * sc) >>> 16;
		axn = xn + ((wn - swn) >>> 1);
		axf = xf + ((wf - swf) >>> 1);

		a = (k * omd * L2T) >> 32;
		b = (k * L2T) >> 16;
		num = ONE32 - exp2_neg(a);
		den = ONE32 - exp2_neg(b);
		if (den == 0) p = omd;
		else p = ((exp2_neg(b - a) >> 16) * num) / den;
		if (p > 65536) p = 65536;
		pi = longint'(p);

		tw = swf * vw;
		th = (longint'(tw) << 8) / ratio;
		e16 = (longint'(hwy_r) * omd) / pd;
		ps = 65536 + ((e16 * strength_r) >> 12);

		iw = swf + (((swn - swf) * pi) >>> 16);
		ypos = yf * vh + (((yn - yf) * vh * pi) >>> 16);
		xpos = axf * vw + (((axn - axf) * vw * pi) >>> 16);
		fx = xpos + ((tw * longint'($signed(offset_r))) >>> 12) - (tw >>> 1);
		fy = ypos - longint'(th >> 1);

		if (th != 0 && ps > 64'hFFFF_FFFF_FFFF_FFFF / th) ht = 8388607;
		else begin
			hu = (th * ps) >> 24;
			ht = hu > 8388607 ? 8388607 : longint'(hu);
		end

		r.x = clamp_s24(fx >>> 8);
		r.y = clamp_s24(fy >>> 8);
		r.w = clamp_u23((iw * vw) >>> 8);
		r.h = clamp_u23(ht);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rect_t exp_r;
		int    nerr;
		if (!arst_n) begin
			dist_r <= 16'd256; hwy_r <= 16'd256; strength_r <= 16'd4096;
			bar_ratio_r <= 16'd256; reg_ratio_r <= 16'd256; curve_r <= 16'd4096;
			offset_r <= 16'd0;
			errors <= 0;
			pending <= 0;
			rect_q.delete();
		end else begin
			nerr = 0;
			// prediction uses the settings in force before this edge
			if (start && !busy)
				rect_q.push_back(glyph_rect(depth, near_y, far_y, near_x, far_x, near_width,
					far_width, width_scale, is_bar, view_width, view_height));
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_PLAYER_DISTANCE: dist_r <= cfg_data;
					REG_HIGHWAY_DEPTH:   hwy_r <= cfg_data;
					REG_PERSP_STRENGTH:  strength_r <= cfg_data;
					REG_BAR_RATIO:       bar_ratio_r <= cfg_data;
					REG_REGULAR_RATIO:   reg_ratio_r <= cfg_data;
					REG_CURVE_EXPONENT:  curve_r <= cfg_data;
					REG_OFFSET_MULT:     offset_r <= cfg_data;
					default: ;
				endcase
			end
			if (done) begin
				if (rect_q.size() == 0) begin
					$error("result word with nothing expected");
					nerr++;
				end else begin
					exp_r = rect_q.pop_front();
					if (rect_x !== exp_r.x) begin
						$error("rect_x: expected %0d, got %0d", exp_r.x, rect_x);
						nerr++;
					end
					if (rect_y !== exp_r.y) begin
						$error("rect_y: expected %0d, got %0d", exp_r.y, rect_y);
						nerr++;
					end
					if (rect_width !== exp_r.w) begin
						$error("rect_width: expected %0d, got %0d", exp_r.w, rect_width);
						nerr++;
					end
					if (rect_height !== exp_r.h) begin
						$error("rect_height: expected %0d, got %0d", exp_r.h, rect_height);
						nerr++;
					end
				end
			end
			errors <= errors + nerr;
			pending <= rect_q.size();
		end
	end
endmodule

>>> tb/sv/perspective_glyph_rect_tb.sv
// Testbench top: drives glyph words and register writes, and gives the verdict.
module perspective_glyph_rect_tb;
	import pgr_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 70;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 240;

	logic clk, arst_n, start, busy, cfg_we, is_bar, done;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;
	logic [16:0] depth, near_width, far_width, width_scale;
	logic signed [17:0] near_y, far_y, near_x, far_x;
	logic [13:0] view_width, view_height;
	logic signed [23:0] rect_x, rect_y;
	logic [22:0] rect_width, rect_height;
	int errors, pending, quiet_cycles, sent;

	perspective_glyph_rect DUT (.*);

	pgr_checker chk (.*);

	always begin
		clk = 1'b1; #6;
		clk = 1'b0; #6;
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic send_glyph(logic [16:0] d, logic [17:0] yn, logic [17:0] yf,
		logic [17:0] xn, logic [17:0] xf, logic [16:0] wn, logic [16:0] wf,
		logic [16:0] sc, logic bar, logic [13:0] vw, logic [13:0] vh);
		depth <= d; near_y <= yn; far_y <= yf; near_x <= xn; far_x <= xf;
		near_width <= wn; far_width <= wf; width_scale <= sc; is_bar <= bar;
		view_width <= vw; view_height <= vh;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		sent++;
	endtask

	task automatic pause(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	function automatic logic [16:0] pick_depth();
		case ($urandom_range(0, 9))
			0: return 17'd0;
			1: return 17'd65536;
			2: return 17'($urandom_range(65537, 131071));
			default: return 17'($urandom_range(0, 65536));
		endcase
	endfunction

	function automatic logic [16:0] pick_scale();
		case ($urandom_range(0, 9))
			0: return 17'd65536;
			1: return 17'($urandom);
			default: return 17'($urandom_range(0, 65536));
		endcase
	endfunction

	function automatic logic [13:0] pick_view();
		case ($urandom_range(0, 9))
			0: return 14'd0;
			1: return 14'd8192;
			2: return 14'($urandom);
			3, 4: return 14'($urandom_range(1, 8192));
			default: return 14'($urandom_range(1, 2048));
		endcase
	endfunction

	task automatic send_random();
		send_glyph(pick_depth(), 18'($urandom), 18'($urandom), 18'($urandom), 18'($urandom),
			17'($urandom), 17'($urandom), pick_scale(), 1'($urandom), pick_view(), pick_view());
	endtask

	task automatic write_reg(reg_idx_t idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	// settle the pipe, then load a full register set
	task automatic load_settings(int ph);
		logic [15:0] v[7];
		start <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		for (int i = 0; i < 7; i++) begin
			case (ph)
				0: v[i] = 16'hFFFF;
				1: v[i] = 16'h0000;
				2: v[i] = (i == 6) ? 16'h8000 : 16'h0001;
				3: v[i] = (i == 6) ? 16'h7FFF : 16'h0100;
				default: v[i] = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 8))
					: 16'($urandom);
			endcase
		end
		for (int i = 0; i < 7; i++) write_reg(reg_idx_t'(i), v[i]);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		depth = '0; near_y = '0; far_y = '0; near_x = '0; far_x = '0;
		near_width = '0; far_width = '0; width_scale = '0; is_bar = 1'b0;
		view_width = '0; view_height = '0;
		sent = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, field extremes
		send_glyph(17'd0, 18'h1FFFF, 18'h20000, 18'h20000, 18'h1FFFF, 17'h1FFFF, 17'h1FFFF,
			17'd65536, 1'b0, 14'd8192, 14'd8192);
		send_glyph(17'd65536, 18'h20000, 18'h1FFFF, 18'h1FFFF, 18'h20000, 17'd0, 17'h1FFFF,
			17'd65536, 1'b1, 14'd8192, 14'd8192);
		send_glyph(17'h1FFFF, 18'h3FFFF, 18'h0, 18'h3FFFF, 18'h0, 17'h1FFFF, 17'd0,
			17'd0, 1'b0, 14'd1, 14'd1);
		send_glyph(17'd32768, 18'h10000, 18'h08000, 18'h04000, 18'h0C000, 17'h08000, 17'h04000,
			17'd32768, 1'b1, 14'd1920, 14'd1080);
		send_glyph(17'd16384, 18'h0, 18'h0, 18'h0, 18'h0, 17'h10000, 17'h10000,
			17'd65536, 1'b0, 14'd0, 14'd0);
		send_glyph(17'd49152, 18'h2AAAA, 18'h15555, 18'h15555, 18'h2AAAA, 17'h15555,
			17'h0AAAA, 17'h15555, 1'b1, 14'h3FFF, 14'h2AAA);
		send_glyph(17'd1, 18'h1, 18'h3FFFF, 18'h1, 18'h3FFFF, 17'd1, 17'd1,
			17'd1, 1'b0, 14'h1555, 14'h3FFF);
		send_glyph(17'd65535, 18'h0, 18'h0, 18'h0, 18'h0, 17'h1FFFF, 17'h1FFFF,
			17'd65536, 1'b1, 14'd8192, 14'd0);
		// zero registers: distance, curve and ratios read as one LSB, the rest stay zero
		load_settings(1);
		send_glyph(17'd0, 18'h10000, 18'h0, 18'h0, 18'h10000, 17'h10000, 17'h08000,
			17'd65536, 1'b0, 14'd1000, 14'd1000);
		send_glyph(17'd20000, 18'h10000, 18'h0, 18'h0, 18'h10000, 17'h10000, 17'h08000,
			17'd65536, 1'b1, 14'd8192, 14'd8192);
		send_glyph(17'd65536, 18'h1FFFF, 18'h20000, 18'h1FFFF, 18'h20000, 17'h1FFFF,
			17'h1FFFF, 17'd65536, 1'b0, 14'd8192, 14'd8192);

		for (int ph = 0; ph < PHASES; ph++) begin
			load_settings(ph == 1 ? 5 : ph);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// no gaps in the final stretch
				if (ph < PHASES - 1 && $urandom_range(0, 7) == 0)
					pause($urandom_range(1, 13));
				send_random();
			end
		end
		start <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Ran %0d glyph words over %0d register sets, extremes and zero registers incl.",
			sent, PHASES + 2);
		$display("Depth saturation, zero view size and degenerate curve exercised.");
		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end
endmodule

>>> sim.f
hw/rtl/pgr_pkg.sv
hw/rtl/pgr_div.sv
hw/rtl/perspective_glyph_rect.sv
tb/sv/pgr_checker.sv
tb/sv/perspective_glyph_rect_tb.sv
